FILE: sv/ctvd_pkg.sv
// Types and constants shared by the chirp-then-voice detector.
`timescale 1ns / 1ps

package ctvd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ENERGY_W = 19;
    localparam int QUIET_W  = 8;
    localparam int STRIDE_W = 12;
    localparam int FRAME_W  = 16;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = ENERGY_W;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
    localparam logic [QUIET_W-1:0]  QUIET_MAX  = '1;
    localparam logic [FRAME_W-1:0]  FRAME_MAX  = '1;

    localparam logic [ENERGY_W-1:0] THRESHOLD_RESET = 19'd2000;
    localparam logic [QUIET_W-1:0]  QUIET_LIMIT_RESET = 8'd5;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd220;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENERGY_THRESHOLD  = 2'd0,
        CFG_QUIET_FRAME_LIMIT = 2'd1,
        CFG_PROBE_STRIDE      = 2'd2
    } cfg_index_t;

    typedef enum logic [CODE_W-1:0] {
        PH_WAIT_CHIRP_START = 3'd0,
        PH_WAIT_CHIRP_END   = 3'd1,
        PH_WAIT_VOICE_START = 3'd2,
        PH_WAIT_VOICE_END   = 3'd3,
        PH_DONE             = 3'd4
    } phase_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE        = 3'd0,
        EV_CHIRP_START = 3'd1,
        EV_CHIRP_END   = 3'd2,
        EV_VOICE_START = 3'd3,
        EV_VOICE_END   = 3'd4
    } event_t;

endpackage

FILE: sv/ctvd_if.sv
// Valid/ready channel interfaces for the sample input and the detection results.
`timescale 1ns / 1ps

interface ctvd_in_if;
    import ctvd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_last;
    logic                       restart;

    modport source (output valid, output sample, output frame_last, output restart,
                    input ready);
    modport sink   (input valid, input sample, input frame_last, input restart,
                    output ready);
endinterface

interface ctvd_out_if;
    import ctvd_pkg::*;

    logic                valid;
    logic                ready;
    logic [CODE_W-1:0]   event_res;
    logic [CODE_W-1:0]   detector_state;
    logic [ENERGY_W-1:0] frame_energy;
    logic [FRAME_W-1:0]  frame_number;

    modport source (output valid, output event_res, output detector_state,
                    output frame_energy, output frame_number, input ready);
    modport sink   (input valid, input event_res, input detector_state,
                    input frame_energy, input frame_number, output ready);
endinterface

FILE: sv/chirp_then_voice_detector_top.sv
// Frame energy detector that finds a chirp followed by a voice segment.
//
//  channel   dir  handshake      payload
//  audio     in   valid/ready    sample, frame_last, restart
//  result    out  valid/ready    event_res, detector_state, frame_energy, frame_number
//  cfg       in   cfg_we         cfg_index, cfg_wdata
//
// One transaction per cycle: accumulation and the phase step for a sample are done in
// the accept cycle, and a frame result appears in the result register the cycle after.
// The single result register sets the rate; audio stays ready while it is empty or
// being drained, so a stall downstream only holds the input when a result is waiting.
// Reset clears phase, counters and the result valid; config registers return to their defaults.
`timescale 1ns / 1ps

module chirp_then_voice_detector_top #(
    parameter int PROBE_COUNT = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ctvd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctvd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    ctvd_in_if.sink                       audio,
    ctvd_out_if.source                    result
);
    import ctvd_pkg::*;

    localparam int PROBE_W = $clog2(PROBE_COUNT + 1);

    logic [ENERGY_W-1:0] threshold_reg;
    logic [QUIET_W-1:0]  quiet_limit_reg;
    logic [STRIDE_W-1:0] stride_reg;

    phase_t              phase_reg, phase_next;
    logic [QUIET_W-1:0]  quiet_reg, quiet_next;
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [STRIDE_W-1:0] pos_reg, pos_next;
    logic [PROBE_W-1:0]  probes_reg, probes_next;
    logic [FRAME_W-1:0]  frame_reg, frame_next;

    logic                out_valid_reg, out_valid_next;
    event_t              event_reg, event_next;
    phase_t              state_out_reg;
    logic [ENERGY_W-1:0] energy_out_reg;
    logic [FRAME_W-1:0]  frame_out_reg;

    logic                accept;
    logic                res_load;
    logic [STRIDE_W-1:0] stride_eff;
    logic [SAMPLE_W:0]   magnitude;
    logic [ENERGY_W:0]   sum_wide;
    logic [ENERGY_W-1:0] energy_acc;
    logic [STRIDE_W:0]   pos_inc;
    logic [QUIET_W-1:0]  quiet_inc;
    logic                take_probe;

    assign audio.ready = !out_valid_reg || result.ready;
    assign accept      = audio.valid && audio.ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= THRESHOLD_RESET;
            quiet_limit_reg <= QUIET_LIMIT_RESET;
            stride_reg      <= STRIDE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENERGY_THRESHOLD:  threshold_reg   <= cfg_wdata;
                CFG_QUIET_FRAME_LIMIT: quiet_limit_reg <= cfg_wdata[QUIET_W-1:0];
                CFG_PROBE_STRIDE:      stride_reg      <= cfg_wdata[STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-sample datapath: magnitude, saturating accumulate, probe position
    always_comb
    begin
        stride_eff = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
        magnitude  = audio.sample[SAMPLE_W-1]
                   ? (SAMPLE_W+1)'(-{audio.sample[SAMPLE_W-1], audio.sample})
                   : (SAMPLE_W+1)'(audio.sample);
        take_probe = (pos_reg == '0) && (probes_reg < PROBE_W'(PROBE_COUNT));
        sum_wide   = {1'b0, energy_reg} + (ENERGY_W+1)'(magnitude);
        if (!take_probe)
            energy_acc = energy_reg;
        else if (sum_wide[ENERGY_W])
            energy_acc = ENERGY_MAX;
        else
            energy_acc = sum_wide[ENERGY_W-1:0];
        pos_inc   = {1'b0, pos_reg} + (STRIDE_W+1)'(1);
        quiet_inc = (quiet_reg != QUIET_MAX) ? quiet_reg + QUIET_W'(1) : quiet_reg;
    end

    // Phase machine stepped at a frame end; restart clears it, and frame bookkeeping runs per sample
    always_comb
    begin
        phase_next  = phase_reg;
        quiet_next  = quiet_reg;
        energy_next = energy_reg;
        pos_next    = pos_reg;
        probes_next = probes_reg;
        frame_next  = frame_reg;
        event_next  = EV_NONE;
        res_load    = 1'b0;

        if (accept)
        begin
            if (audio.restart)
            begin
                phase_next  = PH_WAIT_CHIRP_START;
                quiet_next  = '0;
                energy_next = '0;
                pos_next    = '0;
                probes_next = '0;
                frame_next  = '0;
            end
            else
            begin
                energy_next = energy_acc;
                probes_next = take_probe ? probes_reg + PROBE_W'(1) : probes_reg;
                pos_next    = (pos_inc >= {1'b0, stride_eff}) ? '0 : pos_inc[STRIDE_W-1:0];

                if (audio.frame_last)
                begin
                    res_load = 1'b1;
                    unique case (phase_reg)
                        PH_WAIT_CHIRP_START:
                            if (energy_acc > threshold_reg)
                            begin
                                phase_next = PH_WAIT_CHIRP_END;
                                event_next = EV_CHIRP_START;
                            end
                        PH_WAIT_CHIRP_END:
                            if (energy_acc < threshold_reg)
                            begin
                                phase_next = PH_WAIT_VOICE_START;
                                event_next = EV_CHIRP_END;
                            end
                        PH_WAIT_VOICE_START:
                            if (energy_acc > threshold_reg)
                            begin
                                phase_next = PH_WAIT_VOICE_END;
                                event_next = EV_VOICE_START;
                            end
                        PH_WAIT_VOICE_END:
                            if (energy_acc < threshold_reg)
                            begin
                                // end voice only once the quiet run exceeds the limit
                                if (quiet_inc > quiet_limit_reg)
                                begin
                                    phase_next = PH_DONE;
                                    event_next = EV_VOICE_END;
                                    quiet_next = '0;
                                end
                                else
                                    quiet_next = quiet_inc;
                            end
                            else
                                quiet_next = '0;
                        default: ;
                    endcase
                    frame_next  = (frame_reg != FRAME_MAX) ? frame_reg + FRAME_W'(1)
                                                           : frame_reg;
                    energy_next = '0;
                    pos_next    = '0;
                    probes_next = '0;
                end
            end
        end

        if (res_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT_CHIRP_START;
            quiet_reg     <= '0;
            energy_reg    <= '0;
            pos_reg       <= '0;
            probes_reg    <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            quiet_reg     <= quiet_next;
            energy_reg    <= energy_next;
            pos_reg       <= pos_next;
            probes_reg    <= probes_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold until the next frame end
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            event_reg      <= event_next;
            state_out_reg  <= phase_next;
            energy_out_reg <= energy_acc;
            frame_out_reg  <= frame_reg;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.event_res      = event_reg;
    assign result.detector_state = state_out_reg;
    assign result.frame_energy   = energy_out_reg;
    assign result.frame_number   = frame_out_reg;

endmodule
